/* rtl/cic_pkg.sv */
// Shared types, sizes and codes for the circular image convolution block.
package cic_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int MAX_KERNEL = 15;

	localparam int ROW_W   = 6;
	localparam int SIZE_W  = 7;
	localparam int SIDE_W  = 4;
	localparam int VAL_W   = 16;
	localparam int PIX_W   = 32;
	localparam int FRAC_W  = 15;

	localparam int XW      = $clog2(MAX_WIDTH);
	localparam int YW      = $clog2(MAX_HEIGHT);
	localparam int KIW     = $clog2(MAX_KERNEL + 1);
	localparam int IMG_AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int KER_AW  = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
	localparam int PROD_W  = 2 * VAL_W;
	localparam int ACC_W   = PROD_W + $clog2(MAX_KERNEL * MAX_KERNEL + 1) + 1;

	typedef enum logic [1:0] {
		KIND_KERNEL = 2'd0,
		KIND_IMAGE  = 2'd1,
		KIND_READ   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_BIG   = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_SIDE   = 2'd2;

	typedef struct packed {
		kind_t                    kind;
		logic [ROW_W-1:0]         row;
		logic [ROW_W-1:0]         col;
		logic signed [VAL_W-1:0]  value;
	} in_word_t;

	typedef struct packed {
		logic signed [PIX_W-1:0]  pixel_out;
		status_t                  status;
	} out_word_t;

	typedef struct packed {
		logic               valid;
		logic               last;
		logic [IMG_AW-1:0]  img_addr;
		logic [KER_AW-1:0]  ker_addr;
	} tap_t;

	typedef struct packed {
		logic                     valid;
		logic                     last;
		logic signed [VAL_W-1:0]  coef;
		logic signed [VAL_W-1:0]  pix;
	} mac_in_t;

endpackage

/* rtl/cic_seq.sv */
// Tap sequencer: walks kernel taps and wrapped image coordinates, one tap per cycle.
module cic_seq
	import cic_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [ROW_W-1:0]   y,
	input  logic [ROW_W-1:0]   x,
	input  logic [SIZE_W-1:0]  width,
	input  logic [SIZE_W-1:0]  height,
	input  logic [SIDE_W-1:0]  side,
	output tap_t               tap
);

	logic              run_q;
	logic [KIW-1:0]    ky_q, kx_q;
	logic [YW-1:0]     iy_q;
	logic [XW-1:0]     ix_q, ix0_q;

	logic [SIZE_W:0]   half, ysum, xsum;
	logic [YW-1:0]     iy0;
	logic [XW-1:0]     ix0;
	logic [KIW-1:0]    kmax;
	logic              row_end, last;

	assign half = (SIZE_W+1)'(side >> 1);
	assign ysum = (SIZE_W+1)'(y) + half;
	assign xsum = (SIZE_W+1)'(x) + half;
	assign iy0  = (ysum >= (SIZE_W+1)'(height)) ? YW'(ysum - (SIZE_W+1)'(height)) : YW'(ysum);
	assign ix0  = (xsum >= (SIZE_W+1)'(width)) ? XW'(xsum - (SIZE_W+1)'(width)) : XW'(xsum);

	assign kmax    = KIW'(side - 1'b1);
	assign row_end = (kx_q == kmax);
	assign last    = row_end && (ky_q == kmax);

	assign tap.valid    = run_q;
	assign tap.last     = last;
	assign tap.img_addr = IMG_AW'(IMG_AW'(iy_q) * MAX_WIDTH + IMG_AW'(ix_q));
	assign tap.ker_addr = KER_AW'(KER_AW'(ky_q) * MAX_KERNEL + KER_AW'(kx_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (go) begin
			run_q <= 1'b1;
		end else if (run_q && last) begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			ky_q  <= '0;
			kx_q  <= '0;
			iy_q  <= iy0;
			ix_q  <= ix0;
			ix0_q <= ix0;
		end else if (run_q) begin
			if (row_end) begin
				kx_q <= '0;
				ky_q <= ky_q + 1'b1;
				ix_q <= ix0_q;
				iy_q <= (iy_q == '0) ? YW'(height - 1'b1) : iy_q - 1'b1;
			end else begin
				kx_q <= kx_q + 1'b1;
				ix_q <= (ix_q == '0) ? XW'(width - 1'b1) : ix_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/cic_mac.sv */
// Shared multiply-accumulate unit with floor shift and 32-bit saturation.
module cic_mac
	import cic_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clear,
	input  mac_in_t                  in,
	output logic                     fin,
	output logic signed [PIX_W-1:0]  pixel
);

	localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-PIX_W){1'b0}}, 1'b0, {(PIX_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-PIX_W){1'b1}}, 1'b1, {(PIX_W-1){1'b0}}};

	logic                      valid_s2, last_s2, fin_q;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q, shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			fin_q    <= 1'b0;
		end else begin
			valid_s2 <= in.valid;
			last_s2  <= in.last;
			fin_q    <= valid_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= in.coef * in.pix;
		if (clear) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign shifted = acc_q >>> FRAC_W;

	always_comb begin
		priority if (shifted > SAT_HI) begin
			pixel = SAT_HI[PIX_W-1:0];
		end else if (shifted < SAT_LO) begin
			pixel = SAT_LO[PIX_W-1:0];
		end else begin
			pixel = shifted[PIX_W-1:0];
		end
	end

	assign fin = fin_q;

endmodule

/* rtl/circular_image_convolution.sv */
// Top level: command decode, size registers, image and kernel memories, result register.
// Loads, errors and unused kinds: result in the cycle after acceptance, one accepted per cycle while idle.
// Reads: the single multiply-accumulate unit takes one kernel tap per cycle from the
//   sequencer via the memory read registers, then the result is registered; busy is high meanwhile.
// Reset (arst_n low, asynchronous) returns sizes to 64 x 64 with kernel side 3; stored
//   entries are not cleared. The result strobe done cannot be stalled by the receiver.
module circular_image_convolution
	import cic_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  in_word_t           cmd,
	output logic               done,
	output out_word_t          result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [SIZE_W-1:0]  cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_CONV = 2'b10
	} state_t;

	state_t               state_q;
	logic                 done_q;
	out_word_t            result_q;
	logic [SIZE_W-1:0]    width_q, height_q;
	logic [SIDE_W-1:0]    side_q;

	logic signed [VAL_W-1:0] image_mem [MAX_WIDTH*MAX_HEIGHT];
	logic signed [VAL_W-1:0] kernel_mem [MAX_KERNEL*MAX_KERNEL];

	logic                 accept, conv_go, img_we, ker_we;
	status_t              acc_status;
	logic [IMG_AW-1:0]    img_waddr;
	logic [KER_AW-1:0]    ker_waddr;
	logic [SIDE_W-1:0]    side_in;

	tap_t                 tap;
	mac_in_t              mac_in;
	logic                 valid_s1, last_s1;
	logic signed [VAL_W-1:0] pix_s1, coef_s1;
	logic                 mac_fin;
	logic signed [PIX_W-1:0] mac_pixel;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q == ST_CONV);
	// sizes stay fixed while a command word is being taken
	assign cfg_ready = (state_q == ST_IDLE) && !start;
	assign done      = done_q;
	assign result    = result_q;
	assign side_in   = cfg_data[SIDE_W-1:0];

	assign img_waddr = IMG_AW'(IMG_AW'(cmd.row) * MAX_WIDTH + IMG_AW'(cmd.col));
	assign ker_waddr = KER_AW'(KER_AW'(cmd.row) * MAX_KERNEL + KER_AW'(cmd.col));

	always_comb begin
		acc_status = STAT_OK;
		conv_go    = 1'b0;
		img_we     = 1'b0;
		ker_we     = 1'b0;
		unique case (cmd.kind)
			KIND_KERNEL: begin
				if (cmd.row < ROW_W'(side_q) && cmd.col < ROW_W'(side_q)) ker_we = accept;
				else acc_status = STAT_RANGE;
			end
			KIND_IMAGE: begin
				if (SIZE_W'(cmd.row) < height_q && SIZE_W'(cmd.col) < width_q) img_we = accept;
				else acc_status = STAT_RANGE;
			end
			KIND_READ: begin
				if (SIZE_W'(side_q) > width_q || SIZE_W'(side_q) > height_q)
					acc_status = STAT_BIG;
				else if (SIZE_W'(cmd.row) >= height_q || SIZE_W'(cmd.col) >= width_q)
					acc_status = STAT_RANGE;
				else
					conv_go = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			width_q  <= SIZE_W'(MAX_WIDTH);
			height_q <= SIZE_W'(MAX_HEIGHT);
			side_q   <= SIDE_W'(3);
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			valid_s1 <= tap.valid;
			last_s1  <= tap.last;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						done_q <= !conv_go;
						if (conv_go) state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (mac_fin) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_WIDTH: begin
						if (cfg_data == '0) width_q <= SIZE_W'(1);
						else if (cfg_data > SIZE_W'(MAX_WIDTH)) width_q <= SIZE_W'(MAX_WIDTH);
						else width_q <= cfg_data;
					end
					REG_HEIGHT: begin
						if (cfg_data == '0) height_q <= SIZE_W'(1);
						else if (cfg_data > SIZE_W'(MAX_HEIGHT)) height_q <= SIZE_W'(MAX_HEIGHT);
						else height_q <= cfg_data;
					end
					REG_SIDE: begin
						if (side_in == '0) side_q <= SIDE_W'(1);
						else if (side_in > SIDE_W'(MAX_KERNEL)) side_q <= SIDE_W'(MAX_KERNEL);
						else side_q <= side_in;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (img_we) image_mem[img_waddr] <= cmd.value;
		if (ker_we) kernel_mem[ker_waddr] <= cmd.value;
		pix_s1  <= image_mem[tap.img_addr];
		coef_s1 <= kernel_mem[tap.ker_addr];
		if (accept) begin
			result_q.pixel_out <= '0;
			result_q.status    <= acc_status;
		end else if (mac_fin) begin
			result_q.pixel_out <= mac_pixel;
			result_q.status    <= STAT_OK;
		end
	end

	cic_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (accept && conv_go),
		.y      (cmd.row),
		.x      (cmd.col),
		.width  (width_q),
		.height (height_q),
		.side   (side_q),
		.tap    (tap)
	);

	assign mac_in.valid = valid_s1;
	assign mac_in.last  = last_s1;
	assign mac_in.coef  = coef_s1;
	assign mac_in.pix   = pix_s1;

	cic_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (accept && conv_go),
		.in     (mac_in),
		.fin    (mac_fin),
		.pixel  (mac_pixel)
	);

endmodule

/* tb/sv/circular_image_convolution_tb.sv */
// Self-checking random testbench for the circular image convolution block.
`timescale 1ns / 100ps

module circular_image_convolution_tb;
	import cic_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = MAX_KERNEL * MAX_KERNEL + 16;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int FIXED_PLANS = 9;
	localparam int PHASES = 13;

	logic clk = 1'b0;
	logic arst_n;
	logic start = 1'b0;
	logic busy;
	in_word_t cmd = '0;
	logic done;
	out_word_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [SIZE_W-1:0] cfg_data;

	circular_image_convolution uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow of the block's stores and size registers
	logic signed [VAL_W-1:0] image_mem [MAX_WIDTH*MAX_HEIGHT];
	logic signed [VAL_W-1:0] kernel_mem [MAX_KERNEL*MAX_KERNEL];
	bit img_filled [MAX_WIDTH*MAX_HEIGHT];
	bit ker_filled [MAX_KERNEL*MAX_KERNEL];
	int cur_w = MAX_WIDTH;
	int cur_h = MAX_HEIGHT;
	int cur_k = 3;

	in_word_t cmd_queue [$];
	out_word_t expected_pixels [$];
	int issued = 0;
	int answered = 0;
	int failures = 0;
	int cycles = 0;
	bit took = 1'b0;
	int burst_left = 1;
	int gap_left = 0;

	// size register values as written, out-of-range ones included
	int plan_w [FIXED_PLANS] = '{0, 127, 5, 2, 15, 3, 64, 16, 1};
	int plan_h [FIXED_PLANS] = '{0, 64, 7, 3, 15, 64, 1, 9, 40};
	int plan_k [FIXED_PLANS] = '{16, 15, 3, 4, 15, 2, 1, 5, 127};

	always #5 clk = ~clk;

	function automatic int clamp_size(int v, int hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic out_word_t predict_word(in_word_t w);
		out_word_t r;
		longint acc;
		longint q;
		int half;
		int iy;
		int ix;
		r.pixel_out = '0;
		r.status = STAT_OK;
		case (w.kind)
		KIND_KERNEL: begin
			if (w.row < cur_k && w.col < cur_k)
				kernel_mem[w.row * MAX_KERNEL + w.col] = w.value;
			else
				r.status = STAT_RANGE;
		end
		KIND_IMAGE: begin
			if (w.row < cur_h && w.col < cur_w)
				image_mem[w.row * MAX_WIDTH + w.col] = w.value;
			else
				r.status = STAT_RANGE;
		end
		KIND_READ: begin
			if (cur_k > cur_w || cur_k > cur_h) begin
				r.status = STAT_BIG;
			end else if (w.row >= cur_h || w.col >= cur_w) begin
				r.status = STAT_RANGE;
			end else begin
				acc = 0;
				half = cur_k / 2;
				for (int ky = 0; ky < cur_k; ky++) begin
					iy = (int'(w.row) + cur_h + half - ky) % cur_h;
					for (int kx = 0; kx < cur_k; kx++) begin
						ix = (int'(w.col) + cur_w + half - kx) % cur_w;
						acc += longint'(kernel_mem[ky * MAX_KERNEL + kx]) *
							longint'(image_mem[iy * MAX_WIDTH + ix]);
					end
				end
				// arithmetic shift floors toward minus infinity
				q = acc >>> FRAC_W;
				if (q > 64'sd2147483647)
					r.pixel_out = 32'sh7fffffff;
				else if (q < -64'sd2147483648)
					r.pixel_out = 32'sh80000000;
				else
					r.pixel_out = q[PIX_W-1:0];
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	function automatic in_word_t make_word(logic [1:0] kind, int row, int col,
			logic [VAL_W-1:0] value);
		in_word_t w;
		w.kind = kind_t'(kind);
		w.row = row[ROW_W-1:0];
		w.col = col[ROW_W-1:0];
		w.value = value;
		return w;
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
		0: return 16'h7fff;
		1: return 16'h8000;
		2: return 16'h0000;
		3: return 16'hffff;
		default: return VAL_W'($urandom());
		endcase
	endfunction

	// an in-range read first gets loads for every kernel tap and window pixel not yet written
	task automatic queue_word(input in_word_t w);
		int half;
		int iy;
		int ix;
		if (w.kind == KIND_READ && cur_k <= cur_w && cur_k <= cur_h &&
				w.row < cur_h && w.col < cur_w) begin
			half = cur_k / 2;
			for (int ky = 0; ky < cur_k; ky++) begin
				for (int kx = 0; kx < cur_k; kx++) begin
					if (!ker_filled[ky * MAX_KERNEL + kx])
						queue_word(make_word(KIND_KERNEL, ky, kx, pick_value()));
				end
			end
			for (int ky = 0; ky < cur_k; ky++) begin
				iy = (int'(w.row) + cur_h + half - ky) % cur_h;
				for (int kx = 0; kx < cur_k; kx++) begin
					ix = (int'(w.col) + cur_w + half - kx) % cur_w;
					if (!img_filled[iy * MAX_WIDTH + ix])
						queue_word(make_word(KIND_IMAGE, iy, ix, pick_value()));
				end
			end
		end else if (w.kind == KIND_KERNEL && w.row < cur_k && w.col < cur_k) begin
			ker_filled[w.row * MAX_KERNEL + w.col] = 1'b1;
		end else if (w.kind == KIND_IMAGE && w.row < cur_h && w.col < cur_w) begin
			img_filled[w.row * MAX_WIDTH + w.col] = 1'b1;
		end
		cmd_queue.push_back(w);
		issued++;
	endtask

	task automatic random_items(input int count);
		int stop;
		int sel;
		stop = issued + count;
		while (issued < stop) begin
			sel = $urandom_range(0, 99);
			if (sel < 35)
				queue_word(make_word(KIND_READ, $urandom_range(0, cur_h - 1),
					$urandom_range(0, cur_w - 1), VAL_W'($urandom())));
			else if (sel < 60)
				queue_word(make_word(KIND_IMAGE, $urandom_range(0, cur_h - 1),
					$urandom_range(0, cur_w - 1), pick_value()));
			else if (sel < 75)
				queue_word(make_word(KIND_KERNEL, $urandom_range(0, cur_k - 1),
					$urandom_range(0, cur_k - 1), pick_value()));
			else
				queue_word(make_word(2'($urandom_range(0, 3)), $urandom_range(0, 63),
					$urandom_range(0, 63), pick_value()));
		end
	endtask

	task automatic write_size(input logic [1:0] index, input logic [SIZE_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (answered < issued);
	endtask

	// driver: bursts of words with random gaps
	always @(negedge clk) begin
		logic go;
		in_word_t nxt;
		go = start;
		nxt = cmd;
		if (!arst_n) begin
			go = 1'b0;
		end else if (!start || took) begin
			go = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (cmd_queue.size() > 0) begin
				nxt = cmd_queue.pop_front();
				go = 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
						$urandom_range(1, 20);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
		start <= go;
		cmd <= nxt;
	end

	// monitor: check results, predict accepted words, track size writes
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n) begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("%0t: timeout after %0d cycles", $time, cycles);
				$display("Regression FAIL");
				$finish;
			end else begin
				if (done) begin
					answered++;
					if (expected_pixels.size() == 0) begin
						failures++;
						$display("%0t: unexpected word, pixel_out %0d status %0d",
							$time, result.pixel_out, result.status);
					end else begin
						want = expected_pixels.pop_front();
						if (result.pixel_out !== want.pixel_out) begin
							failures++;
							$display("%0t: pixel_out expected %0d actual %0d",
								$time, want.pixel_out, result.pixel_out);
						end
						if (result.status !== want.status) begin
							failures++;
							$display("%0t: status expected %0d actual %0d",
								$time, want.status, result.status);
						end
					end
				end
				took = start && !busy;
				if (took)
					expected_pixels.push_back(predict_word(cmd));
				if (cfg_valid && cfg_ready) begin
					case (cfg_index)
					REG_WIDTH: cur_w = clamp_size(cfg_data, MAX_WIDTH);
					REG_HEIGHT: cur_h = clamp_size(cfg_data, MAX_HEIGHT);
					REG_SIDE: cur_k = clamp_size(cfg_data[SIDE_W-1:0], MAX_KERNEL);
					default: ;
					endcase
				end
			end
		end
	end

	initial begin
		int w;
		int h;
		int k;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;

		// directed: out-of-range taps, extreme values, reads wrapping at both corners
		queue_word(make_word(KIND_KERNEL, 3, 0, 16'h1234));
		queue_word(make_word(KIND_KERNEL, 0, 3, 16'h1234));
		queue_word(make_word(KIND_KERNEL, 0, 0, 16'h8000));
		queue_word(make_word(KIND_KERNEL, 1, 1, 16'h7fff));
		queue_word(make_word(KIND_IMAGE, 0, 0, 16'h8000));
		queue_word(make_word(KIND_IMAGE, 63, 63, 16'h7fff));
		queue_word(make_word(KIND_READ, 0, 0, 16'hffff));
		queue_word(make_word(KIND_READ, 63, 63, 16'h0000));
		queue_word(make_word(KIND_SPARE, 63, 63, 16'hffff));
		random_items(150);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			if (p < FIXED_PLANS) begin
				w = plan_w[p];
				h = plan_h[p];
				k = plan_k[p];
			end else begin
				w = $urandom_range(1, 24);
				h = $urandom_range(1, 24);
				k = $urandom_range(1, 9);
			end
			write_size(REG_WIDTH, SIZE_W'(w));
			write_size(REG_HEIGHT, SIZE_W'(h));
			write_size(REG_SIDE, SIZE_W'(k));
			if (p == 0)
				write_size(REG_SPARE, 7'h7f);
			random_items(150);
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
